// ===== src/wswt_pkg.sv =====
// Shared types and constants for the working-set window tracker.
// Holds the stream beat layouts and the fixed field widths.
// No dependencies; imported by the core and by its checker.
package wswt_pkg;

  // Fixed widths of the transaction fields.
  localparam int PID_W       = 2;
  localparam int PAGE_W      = 20;
  localparam int SIZE_W      = 5;
  localparam int CFG_W       = 5;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Window size taken after reset.
  localparam logic [CFG_W-1:0] CFG_WINDOW_RESET = 5'd16;

  // Input beat, lowest bits first: process_id, page_number, zero padding.
  typedef struct packed {
    logic [1:0]        pad;
    logic [PAGE_W-1:0] page_number;
    logic [PID_W-1:0]  process_id;
  } in_beat_t;

  // Result beat, lowest bits first: victim_valid, victim_page,
  // newcomer_added, set_size, zero padding.
  typedef struct packed {
    logic [4:0]        pad;
    logic [SIZE_W-1:0] set_size;
    logic              newcomer_added;
    logic [PAGE_W-1:0] victim_page;
    logic              victim_valid;
  } out_beat_t;

endpackage

// ===== src/wswt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no reset on the storage.
// No dependencies.
module wswt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

// ===== src/working_set_window_tracker_core.sv =====
// Working-set window tracker: per-process sliding window of page references.
// Each reference passes S_META, S_OLD when the oldest reference is dropped,
// S_SCAN over the stored entries, S_WRITE and S_OUT, which sets out_tvalid and
// stalls while the result register is full; a new reference is taken only in
// S_IDLE. The single compare pass reads one stored page per cycle from the RAM.
// Reset (rst_n, synchronous, active low) empties every window, sets size 16.
module working_set_window_tracker_core #(
  parameter int WINDOW_DEPTH  = 16,
  parameter int NUM_PROCESSES = 2,
  parameter int PAGE_BITS     = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Fields from bit 0: process_id[1:0], page_number[21:2], zero padding.
  input  logic [wswt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0: victim_valid[0], victim_page[20:1], newcomer_added[21],
  // set_size[26:22], zero padding.
  output logic [wswt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_wr_en,
  input  logic [wswt_pkg::CFG_W-1:0]       cfg_wr_data
);
  import wswt_pkg::*;

  localparam int HEAD_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int PIDX_W  = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int PAGES   = NUM_PROCESSES * WINDOW_DEPTH;
  localparam int PADDR_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int META_W  = HEAD_W + 2 * FILL_W;

  // Per-process bookkeeping kept in the metadata RAM.
  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [FILL_W-1:0] fill;
    logic [FILL_W-1:0] cnt;
  } meta_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_META,
    S_OLD,
    S_SCAN,
    S_WRITE,
    S_OUT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CFG_W-1:0]         ws_r, ws_nxt;
  logic [NUM_PROCESSES-1:0] valid_r, valid_nxt;
  logic [PIDX_W-1:0]        pidx_r, pidx_nxt;
  logic [PAGE_BITS-1:0]     page_r, page_nxt;
  logic [PADDR_W-1:0]       base_r, base_nxt;
  logic [HEAD_W-1:0]        head_r, head_nxt;
  logic [FILL_W-1:0]        fill_r, fill_nxt;
  logic [FILL_W-1:0]        cnt_r, cnt_nxt;
  logic                     drop_r, drop_nxt;
  logic [PAGE_BITS-1:0]     oldest_r, oldest_nxt;
  logic [HEAD_W-1:0]        slot_r, slot_nxt;
  logic [FILL_W-1:0]        issue_r, issue_nxt;
  logic                     pend_r, pend_nxt;
  logic                     hit_old_r, hit_old_nxt;
  logic                     hit_new_r, hit_new_nxt;
  logic                     victim_r, victim_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_beat_t                out_beat_r, out_beat_nxt;

  in_beat_t                 in_beat;
  logic                     pid_ok;
  logic [PIDX_W-1:0]        in_pidx;
  logic [FILL_W-1:0]        eff_size;
  meta_t                    meta_rd, meta_cur, meta_wr;
  logic [META_W-1:0]        meta_rdata;
  logic                     meta_we;
  logic [PAGE_BITS-1:0]     page_rdata;
  logic [PADDR_W-1:0]       page_rd_addr;
  logic                     page_we;
  logic [HEAD_W-1:0]        head_inc;
  logic                     victim_now;
  logic                     newc_now;
  logic [FILL_W-1:0]        cnt_after;

  assign in_beat = in_beat_t'(in_tdata);
  assign pid_ok  = (in_beat.process_id != '0) &&
                   (32'(in_beat.process_id) <= NUM_PROCESSES);
  assign in_pidx = PIDX_W'(in_beat.process_id - 2'd1);

  // Window size as used: zero acts as one, oversize is clipped to the depth.
  always_comb begin
    if (ws_r == '0) begin
      eff_size = FILL_W'(1);
    end else if (32'(ws_r) > WINDOW_DEPTH) begin
      eff_size = FILL_W'(WINDOW_DEPTH);
    end else begin
      eff_size = FILL_W'(ws_r);
    end
  end

  // An untouched or freshly cleared process reads as an empty window.
  assign meta_rd  = meta_t'(meta_rdata);
  assign meta_cur = valid_r[pidx_r] ? meta_rd : '0;
  assign head_inc = (meta_cur.head == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 :
                    meta_cur.head + HEAD_W'(1);

  // Result of the finished search.
  assign victim_now = drop_r && !hit_old_r;
  assign newc_now   = !hit_new_r;
  assign cnt_after  = cnt_r - FILL_W'(victim_now && (cnt_r != '0)) + FILL_W'(newc_now);

  assign meta_we      = (state_r == S_WRITE);
  assign page_we      = (state_r == S_WRITE);
  assign meta_wr.head = head_r;
  assign meta_wr.fill = fill_r + FILL_W'(1);
  assign meta_wr.cnt  = cnt_after;

  // Page RAM read address: the oldest entry first, then the scan pointer.
  assign page_rd_addr = (state_r == S_META) ? base_r + PADDR_W'(meta_cur.head) :
                        base_r + PADDR_W'(slot_r);

  // Sequencer: metadata fetch, optional oldest read, one compare per cycle, write-back, result.
  always_comb begin
    state_nxt     = state_r;
    ws_nxt        = ws_r;
    valid_nxt     = valid_r;
    pidx_nxt      = pidx_r;
    page_nxt      = page_r;
    base_nxt      = base_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    oldest_nxt    = oldest_r;
    slot_nxt      = slot_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    hit_old_nxt   = hit_old_r;
    hit_new_nxt   = hit_new_r;
    victim_nxt    = victim_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;

    // The result register empties when the consumer takes it.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid && pid_ok) begin
          pidx_nxt  = in_pidx;
          page_nxt  = PAGE_BITS'(in_beat.page_number);
          base_nxt  = PADDR_W'(in_pidx) * PADDR_W'(WINDOW_DEPTH);
          state_nxt = S_META;
        end
      end
      S_META: begin
        cnt_nxt     = meta_cur.cnt;
        issue_nxt   = '0;
        pend_nxt    = 1'b0;
        hit_old_nxt = 1'b0;
        hit_new_nxt = 1'b0;
        if (meta_cur.fill >= eff_size) begin
          drop_nxt  = 1'b1;
          head_nxt  = head_inc;
          fill_nxt  = meta_cur.fill - FILL_W'(1);
          slot_nxt  = head_inc;
          state_nxt = S_OLD;
        end else begin
          drop_nxt  = 1'b0;
          head_nxt  = meta_cur.head;
          fill_nxt  = meta_cur.fill;
          slot_nxt  = meta_cur.head;
          state_nxt = S_SCAN;
        end
      end
      S_OLD: begin
        oldest_nxt = page_rdata;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        // Compare the page read in the previous cycle against both keys.
        if (pend_r) begin
          if (page_rdata == oldest_r) begin
            hit_old_nxt = 1'b1;
          end
          if (page_rdata == page_r) begin
            hit_new_nxt = 1'b1;
          end
        end
        if (issue_r != fill_r) begin
          issue_nxt = issue_r + FILL_W'(1);
          slot_nxt  = (slot_r == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + HEAD_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        // Slot pointer now sits at the tail, where the new page goes.
        valid_nxt[pidx_r] = 1'b1;
        victim_nxt        = victim_now;
        hit_new_nxt       = !newc_now;
        cnt_nxt           = cnt_after;
        state_nxt         = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_beat_nxt.pad            = '0;
          out_beat_nxt.set_size       = SIZE_W'(cnt_r);
          out_beat_nxt.newcomer_added = !hit_new_r;
          out_beat_nxt.victim_valid   = victim_r;
          out_beat_nxt.victim_page    = victim_r ? PAGE_W'(oldest_r) : '0;
          out_valid_nxt               = 1'b1;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new window size empties every window.
    if (cfg_wr_en) begin
      ws_nxt    = cfg_wr_data;
      valid_nxt = '0;
    end
  end

  // State, control and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ws_r        <= CFG_WINDOW_RESET;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ws_r        <= ws_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pidx_r     <= pidx_nxt;
    page_r     <= page_nxt;
    base_r     <= base_nxt;
    head_r     <= head_nxt;
    fill_r     <= fill_nxt;
    cnt_r      <= cnt_nxt;
    drop_r     <= drop_nxt;
    oldest_r   <= oldest_nxt;
    slot_r     <= slot_nxt;
    issue_r    <= issue_nxt;
    pend_r     <= pend_nxt;
    hit_old_r  <= hit_old_nxt;
    hit_new_r  <= hit_new_nxt;
    victim_r   <= victim_nxt;
    out_beat_r <= out_beat_nxt;
  end

  // Per-process head, fill and set size.
  wswt_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_PROCESSES)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (pidx_r),
    .wr_data (META_W'(meta_wr)),
    .rd_addr (in_pidx),
    .rd_data (meta_rdata)
  );

  // Ring of stored page references, one window per process.
  wswt_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (PAGES)
  ) u_page_ram (
    .clk     (clk),
    .wr_en   (page_we),
    .wr_addr (base_r + PADDR_W'(slot_r)),
    .wr_data (page_r),
    .rd_addr (page_rd_addr),
    .rd_data (page_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_beat_r);

endmodule

// ===== src/wswt_checker.sv =====
// Port-level checker for the working-set window tracker core.
// Depends on wswt_pkg; attached to the core by the bind statement below.
module wswt_checker #(
  parameter int WINDOW_DEPTH = 16
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic [wswt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [wswt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready
);
  import wswt_pkg::*;

  in_beat_t  in_beat;
  out_beat_t out_beat;

  assign in_beat  = in_beat_t'(in_tdata);
  assign out_beat = out_beat_t'(out_tdata);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Process 1 always exists, so its transaction occupies the block.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_beat.process_id == 2'd1) |=> !in_tready)
    else $error("block ready again straight after taking a reference");

  // The referenced page is always in the set after an update, so the set size lies between one and the depth.
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_beat.set_size != '0) &&
                   (32'(out_beat.set_size) <= WINDOW_DEPTH))
    else $error("set size out of range");

  // Without a victim the victim page reads as zero.
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_beat.victim_valid |-> out_beat.victim_page == '0)
    else $error("victim page set without a victim");

endmodule

bind working_set_window_tracker_core wswt_checker #(
  .WINDOW_DEPTH (WINDOW_DEPTH)
) u_wswt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tdata    (in_tdata),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .out_tdata   (out_tdata),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready)
);

// ===== verif/tb.sv =====
// Self-checking testbench for working_set_window_tracker_core.
// It drives page references as stream transactions and predicts each result in its own model.
// It depends on wswt_pkg and on the core RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wswt_pkg::*;

  localparam int WIN_DEPTH      = 16;
  localparam int NUM_PROC       = 2;
  localparam int HOLD_OFF       = 32;
  localparam int QUIET_LIMIT    = 4000;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_REFS     = 120;
  localparam int POOL_MAX       = 40;
  localparam logic [PAGE_W-1:0] PAGE_MAX = 20'hFFFFF;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_SLOW} rx_mode_t;

  // One row of the directed table. Rows marked typed carry the expected result.
  typedef struct packed {
    row_kind_t         kind;
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] page;
    logic [CFG_W-1:0]  win;
    logic              typed;
    logic              w_vv;
    logic [PAGE_W-1:0] w_vp;
    logic              w_nc;
    logic [SIZE_W-1:0] w_sz;
  } dir_row_t;

  localparam int DIR_ROWS_N = 22;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    // Fresh windows after reset, size 16.
    '{ROW_REF, 2'd1, 20'h00000, 5'd0,  1'b1, 1'b0, 20'h00000, 1'b1, 5'd1},
    '{ROW_REF, 2'd2, 20'hFFFFF, 5'd0,  1'b1, 1'b0, 20'h00000, 1'b1, 5'd1},
    '{ROW_REF, 2'd1, 20'h00000, 5'd0,  1'b1, 1'b0, 20'h00000, 1'b0, 5'd1},
    // Process ids out of range are dropped without a result; valid ones follow, predicted by the model.
    '{ROW_REF, 2'd0, 20'h00005, 5'd0,  1'b0, 1'b0, 20'h00000, 1'b0, 5'd0},
    '{ROW_REF, 2'd3, 20'hFFFFF, 5'd0,  1'b0, 1'b0, 20'h00000, 1'b0, 5'd0},
    '{ROW_REF, 2'd1, 20'h55555, 5'd0,  1'b0, 1'b0, 20'h00000, 1'b0, 5'd0},
    '{ROW_REF, 2'd2, 20'hAAAAA, 5'd0,  1'b0, 1'b0, 20'h00000, 1'b0, 5'd0},
    '{ROW_REF, 2'd2, 20'hFFFFF, 5'd0,  1'b0, 1'b0, 20'h00000, 1'b0, 5'd0},
    // A window size of zero behaves as one; the victim may rejoin at once.
    '{ROW_CFG, 2'd0, 20'h00000, 5'd0,  1'b0, 1'b0, 20'h00000, 1'b0, 5'd0},
    '{ROW_REF, 2'd1, 20'h00007, 5'd0,  1'b1, 1'b0, 20'h00000, 1'b1, 5'd1},
    '{ROW_REF, 2'd1, 20'h00007, 5'd0,  1'b1, 1'b1, 20'h00007, 1'b1, 5'd1},
    '{ROW_REF, 2'd1, 20'hFFFFF, 5'd0,  1'b1, 1'b1, 20'h00007, 1'b1, 5'd1},
    '{ROW_REF, 2'd2, 20'h00000, 5'd0,  1'b1, 1'b0, 20'h00000, 1'b1, 5'd1},
    // Size two: the dropped page survives while a copy remains in the window.
    '{ROW_CFG, 2'd0, 20'h00000, 5'd2,  1'b0, 1'b0, 20'h00000, 1'b0, 5'd0},
    '{ROW_REF, 2'd2, 20'h00001, 5'd0,  1'b1, 1'b0, 20'h00000, 1'b1, 5'd1},
    '{ROW_REF, 2'd2, 20'h00001, 5'd0,  1'b1, 1'b0, 20'h00000, 1'b0, 5'd1},
    '{ROW_REF, 2'd2, 20'h00002, 5'd0,  1'b0, 1'b0, 20'h00000, 1'b0, 5'd0},
    '{ROW_REF, 2'd2, 20'h00003, 5'd0,  1'b0, 1'b0, 20'h00000, 1'b0, 5'd0},
    // Oversized setting is clamped to the window depth.
    '{ROW_CFG, 2'd0, 20'h00000, 5'd31, 1'b0, 1'b0, 20'h00000, 1'b0, 5'd0},
    '{ROW_REF, 2'd1, 20'h80000, 5'd0,  1'b1, 1'b0, 20'h00000, 1'b1, 5'd1},
    '{ROW_REF, 2'd1, 20'h00001, 5'd0,  1'b1, 1'b0, 20'h00000, 1'b1, 5'd2},
    '{ROW_REF, 2'd2, 20'h00001, 5'd0,  1'b1, 1'b0, 20'h00000, 1'b1, 5'd1}
  };

  localparam logic [CFG_W-1:0] PHASE_WINDOWS [6] = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd17, 5'd2};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;

  // Predictor state: one ring of pages per process.
  logic [PAGE_W-1:0] ring_page [NUM_PROC][WIN_DEPTH];
  int                ring_head [NUM_PROC];
  int                ring_fill [NUM_PROC];
  int                set_count [NUM_PROC];
  logic [CFG_W-1:0]  window_reg;

  out_beat_t pending_results [$];
  int        fail_count = 0;
  int        quiet_cycles = 0;

  rx_mode_t rx_mode = RX_STEADY;
  int       rx_left = 0;
  int       rx_tick = 0;

  working_set_window_tracker_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Empties every window, as a register write or reset does.
  function automatic void clear_windows();
    for (int p = 0; p < NUM_PROC; p++) begin
      ring_head[p] = 0;
      ring_fill[p] = 0;
      set_count[p] = 0;
    end
  endfunction

  function automatic int window_limit(logic [CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > WIN_DEPTH) return WIN_DEPTH;
    return int'(w);
  endfunction

  function automatic bit page_in_window(int p, logic [PAGE_W-1:0] page);
    for (int i = 0; i < ring_fill[p]; i++) begin
      if (ring_page[p][(ring_head[p] + i) % WIN_DEPTH] == page) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one reference to process p and returns the result it yields.
  function automatic out_beat_t track_reference(int p, logic [PAGE_W-1:0] page);
    out_beat_t         res;
    logic [PAGE_W-1:0] oldest;
    bit                joins;
    res = '0;
    if (ring_fill[p] >= window_limit(window_reg)) begin
      oldest = ring_page[p][ring_head[p]];
      ring_head[p] = (ring_head[p] + 1) % WIN_DEPTH;
      ring_fill[p]--;
      if (!page_in_window(p, oldest)) begin
        res.victim_valid = 1'b1;
        res.victim_page  = oldest;
        if (set_count[p] > 0) set_count[p]--;
      end
    end
    joins = !page_in_window(p, page);
    ring_page[p][(ring_head[p] + ring_fill[p]) % WIN_DEPTH] = page;
    ring_fill[p]++;
    if (joins) set_count[p]++;
    res.newcomer_added = joins;
    res.set_size       = set_count[p][SIZE_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Presents one reference and waits for its transaction; tvalid stays high.
  task automatic send_reference(logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page,
                                bit typed, out_beat_t want);
    in_beat_t  beat;
    out_beat_t predicted;
    beat = '0;
    beat.process_id  = pid;
    beat.page_number = page;
    in_tdata  <= beat;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (pid >= 1 && pid <= NUM_PROC) begin
      predicted = track_reference(int'(pid) - 1, page);
      pending_results.insert(pending_results.size(), typed ? want : predicted);
    end
  endtask

  // Holds the sender until every result is back and the core has gone quiet.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_window(logic [CFG_W-1:0] w);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    window_reg = w;
    clear_windows();
  endtask

  // Receiver: switches between always ready, random stalls and a slow pattern.
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STEADY: out_tready <= 1'b1;
      RX_RANDOM: out_tready <= ($urandom_range(0, 2) != 0);
      default:   out_tready <= ((rx_tick % 32) >= 24);
    endcase
  end

  // Result checker: each result transaction against the oldest expectation.
  always @(posedge clk) begin : check_results
    out_beat_t got;
    out_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", got, '0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got.victim_valid !== want.victim_valid)
          report_mismatch("victim_valid", got.victim_valid, want.victim_valid);
        if (got.victim_page !== want.victim_page)
          report_mismatch("victim_page", got.victim_page, want.victim_page);
        if (got.newcomer_added !== want.newcomer_added)
          report_mismatch("newcomer_added", got.newcomer_added, want.newcomer_added);
        if (got.set_size !== want.set_size)
          report_mismatch("set_size", got.set_size, want.set_size);
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    out_beat_t         typed_want;
    logic [PAGE_W-1:0] page_pool [POOL_MAX];
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] page;
    logic [CFG_W-1:0]  win;
    int                pool_n;
    int                sent;
    int                burst_left;
    int                gap;
    bit                no_gaps;
    bit                paused;

    window_reg = CFG_WINDOW_RESET;
    clear_windows();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (int r = 0; r < DIR_ROWS_N; r++) begin
      if (DIR_ROWS[r].kind == ROW_CFG) begin
        write_window(DIR_ROWS[r].win);
      end else begin
        typed_want = '0;
        typed_want.victim_valid   = DIR_ROWS[r].w_vv;
        typed_want.victim_page    = DIR_ROWS[r].w_vp;
        typed_want.newcomer_added = DIR_ROWS[r].w_nc;
        typed_want.set_size       = DIR_ROWS[r].w_sz;
        send_reference(DIR_ROWS[r].pid, DIR_ROWS[r].page, DIR_ROWS[r].typed, typed_want);
      end
    end

    // Random phases, each under its own window size and pool of pages.
    paused = 1'b0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      win = (ph < 6) ? PHASE_WINDOWS[ph] : CFG_W'($urandom_range(0, 31));
      write_window(win);
      pool_n = $urandom_range(1, 2 * window_limit(win) + 4);
      if (pool_n > POOL_MAX) pool_n = POOL_MAX;
      for (int i = 0; i < POOL_MAX; i++) begin
        case ($urandom_range(0, 9))
          0:       page_pool[i] = '0;
          1:       page_pool[i] = PAGE_MAX;
          2:       page_pool[i] = PAGE_W'($urandom_range(0, 7));
          default: page_pool[i] = PAGE_W'($urandom());
        endcase
      end
      no_gaps    = (ph % 3 == 1);
      sent       = 0;
      burst_left = 0;
      while (sent < PHASE_REFS) begin
        // Once in the run, stop mid-phase until every result has returned.
        if (ph == 2 && sent == PHASE_REFS / 2 && !paused) begin
          paused = 1'b1;
          drain_results();
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = no_gaps ? 0 : $urandom_range(0, 12);
          if (gap > 0) begin
            in_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        if ($urandom_range(0, 24) == 0)
          pid = ($urandom_range(0, 1) != 0) ? 2'd3 : 2'd0;
        else
          pid = PID_W'($urandom_range(1, NUM_PROC));
        if ($urandom_range(0, 6) == 0)
          page = PAGE_W'($urandom());
        else
          page = page_pool[$urandom_range(0, pool_n - 1)];
        send_reference(pid, page, 1'b0, '0);
        if (pid >= 1 && pid <= NUM_PROC) sent++;
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wswt_pkg.sv
src/wswt_ram.sv
src/working_set_window_tracker_core.sv
src/wswt_checker.sv
verif/tb.sv
